@@ sv/mbss_pkg.sv @@
// shared types and constants of the masked byte signature scan
`timescale 1ns / 1ps
`default_nettype none
package mbss_pkg;

  localparam int SIG_BYTES  = 16;
  localparam int SIG_IDX_W  = 4;
  localparam int LEN_W      = 5;
  localparam int OFF_OUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [OFF_OUT_W-1:0] match_offset;
  } out_item_t;

  // signature view handed to every window cell
  typedef struct packed {
    logic [SIG_BYTES-1:0][7:0] sig;
    logic [SIG_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
  } sig_cfg_t;

endpackage
`default_nettype wire

@@ sv/masked_byte_signature_scan_unit.sv @@
// top level of the masked byte signature scan
//
// usage
//   in_*  : one byte of the scanned region per request, region_end on the last
//   out_* : one result per region: found with the offset of the first match,
//           or not found when the region closes without one
//   cfg_* : register writes (pattern low, pattern high, care mask, length),
//           always ready, to be issued only while the block is idle
// throughput and result path
//   one byte per cycle sustained while in_stall is low; the window compare over
//   the row of cells and the offset subtract are combinational, and the result
//   goes to the buffer's output register, or its skid register under out_stall
// stall
//   a two-entry result buffer lets scanning run on while a result waits;
//   in_stall rises only once both entries hold results
// reset
//   window, byte count and match flag clear, no results pending,
//   pattern zero, care mask all ones, length one
`timescale 1ns / 1ps
`default_nettype none
module masked_byte_signature_scan_unit #(
  parameter int MAX_SIGNATURE = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire mbss_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output mbss_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mbss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mbss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mbss_pkg::*;

  // cells beyond the longest usable signature never take part
  localparam int WIN   = (MAX_SIGNATURE < SIG_BYTES) ? MAX_SIGNATURE : SIG_BYTES;
  localparam int EXT_W = (OFFSET_BITS > OFF_OUT_W) ? OFFSET_BITS : OFF_OUT_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [SIG_BYTES-1:0]  care_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      len_eff;
  sig_cfg_t              sig_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '1;
      len_r    <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAT_LO: pat_lo_r <= cfg_data;
        CFG_PAT_HI: pat_hi_r <= cfg_data;
        CFG_CARE:   care_r   <= cfg_data[SIG_BYTES-1:0];
        CFG_LEN:    len_r    <= cfg_data[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // length zero behaves as one, anything over the window as the window
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(WIN)) begin
      len_eff = LEN_W'(WIN);
    end else begin
      len_eff = len_r;
    end
    sig_cfg.sig  = {pat_hi_r, pat_lo_r};
    sig_cfg.care = care_r;
    sig_cfg.len  = len_eff;
  end

  // request handshake
  logic in_fire;
  logic skid_full;

  assign in_stall = skid_full;
  assign in_fire  = in_valid && !in_stall;

  // row of window cells, newest byte enters cell 0
  logic [WIN-1:0][7:0] cell_q;
  logic [WIN-1:0]      cell_hit;
  logic                window_match;

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    logic [7:0] cell_din;
    if (i == 0) begin : g_head
      assign cell_din = in_data.data_byte;
    end else begin : g_link
      assign cell_din = cell_q[i-1];
    end
    mbss_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_fire),
      .clear    (in_data.region_end),
      .din      (cell_din),
      .cfg      (sig_cfg),
      .dout     (cell_q[i]),
      .hit      (cell_hit[i])
    );
  end

  assign window_match = &cell_hit;

  // region bookkeeping: saturating byte count and match flag
  logic [OFFSET_BITS-1:0] count_r, count_nxt;
  logic                   matched_r, matched_nxt;
  logic [OFFSET_BITS-1:0] count_inc;
  logic [OFFSET_BITS-1:0] off_full;
  logic [EXT_W-1:0]       off_ext;
  logic                   enough;
  logic                   found_hit;
  logic                   push_valid;
  out_item_t              push_data;

  always_comb begin
    count_inc = (count_r == '1) ? count_r : count_r + OFFSET_BITS'(1);
    enough    = count_inc >= OFFSET_BITS'(len_eff);
    found_hit = !matched_r && enough && window_match;
    // saturated count reports all ones, wider offsets clamp to the port
    off_full  = (count_inc == '1) ? count_inc : count_inc - OFFSET_BITS'(len_eff);
    off_ext   = EXT_W'(off_full);

    push_valid = in_fire && (found_hit || (in_data.region_end && !matched_r));
    push_data.found = found_hit;
    if (!found_hit) begin
      push_data.match_offset = '0;
    end else if (off_ext > EXT_W'(32'hFFFF_FFFF)) begin
      push_data.match_offset = '1;
    end else begin
      push_data.match_offset = off_ext[OFF_OUT_W-1:0];
    end

    count_nxt   = count_r;
    matched_nxt = matched_r;
    if (in_fire) begin
      if (in_data.region_end) begin
        // rearm for the next region
        count_nxt   = '0;
        matched_nxt = 1'b0;
      end else begin
        count_nxt   = count_inc;
        matched_nxt = matched_r || found_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      matched_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      matched_r <= matched_nxt;
    end
  end

  // result buffer
  mbss_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (skid_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

@@ sv/mbss_cell.sv @@
// one window cell: holds one byte, passes it on and compares the incoming byte
`timescale 1ns / 1ps
`default_nettype none
module mbss_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire logic              clear,
  input  wire logic [7:0]        din,
  input  wire mbss_pkg::sig_cfg_t cfg,
  output logic      [7:0]        dout,
  output logic                   hit
);
  import mbss_pkg::*;

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic             in_use;
  logic [LEN_W-1:0] pos;

  // signature byte that lines up with this cell once din lands here
  always_comb begin
    in_use = IDX_L < cfg.len;
    pos    = cfg.len - IDX_L - LEN_W'(1);
    hit    = !in_use || !cfg.care[pos[SIG_IDX_W-1:0]] ||
             (din == cfg.sig[pos[SIG_IDX_W-1:0]]);
  end

  always_comb begin
    byte_nxt = byte_r;
    if (shift_en) begin
      byte_nxt = clear ? 8'd0 : din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign dout = byte_r;

endmodule
`default_nettype wire

@@ sv/mbss_skid.sv @@
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none
module mbss_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  input  wire mbss_pkg::out_item_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mbss_pkg::out_item_t      out_data
);
  import mbss_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      taking;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    taking         = !out_valid_r || !out_stall;
    if (taking) begin
      if (skid_valid_r) begin
        // no push can arrive while the skid is full
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_valid;
        out_data_nxt  = push_data;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ sv/mbss_checker.sv @@
// port-level checks of the signature scan, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mbss_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mbss_pkg::out_item_t out_data
);
  import mbss_pkg::*;

  // nothing pending and no back-pressure straight after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // a not-found result carries a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_offset == '0)
    else $error("not-found result with non-zero offset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind masked_byte_signature_scan_unit mbss_checker u_mbss_checker (.*);
`default_nettype wire

@@ tb/mbss_match_checker.sv @@
// checker that predicts and compares the results of the signature scan
`timescale 1ns / 1ps
module mbss_match_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  mbss_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  mbss_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              reports_waiting,
  output int                              found_checked,
  output int                              absent_checked
);
  import mbss_pkg::*;

  logic [CFG_DATA_W-1:0] sig_lo;
  logic [CFG_DATA_W-1:0] sig_hi;
  logic [SIG_BYTES-1:0]  care;
  logic [LEN_W-1:0]      len_reg;

  logic [7:0]            window [SIG_BYTES];
  logic [OFF_OUT_W-1:0]  bytes_seen;
  logic                  matched;
  out_item_t             pending_reports [$];

  function automatic int unsigned used_len();
    if (len_reg == '0) return 1;
    if (len_reg > SIG_BYTES) return SIG_BYTES;
    return int'(len_reg);
  endfunction

  function automatic logic [7:0] sig_at(int unsigned j);
    logic [CFG_DATA_W-1:0] word;
    word = (j < 8) ? sig_lo : sig_hi;
    return word[(j % 8) * 8 +: 8];
  endfunction

  // oldest byte of the window lines up with signature byte 0
  function automatic bit window_hit(int unsigned n);
    for (int unsigned j = 0; j < n; j++)
      if (care[j] && window[n - 1 - j] != sig_at(j)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void rearm();
    foreach (window[i]) window[i] = '0;
    bytes_seen = '0;
    matched    = 1'b0;
  endfunction

  function automatic void scan_byte(in_item_t item);
    int unsigned n;
    out_item_t   rep;
    n = used_len();
    for (int i = SIG_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = item.data_byte;
    if (bytes_seen != '1) bytes_seen++;
    if (!matched && bytes_seen >= n && window_hit(n)) begin
      rep.found        = 1'b1;
      rep.match_offset = (bytes_seen == '1) ? '1 : bytes_seen - n;
      pending_reports.push_back(rep);
      matched = 1'b1;
    end
    if (item.region_end) begin
      if (!matched) begin
        rep.found        = 1'b0;
        rep.match_offset = '0;
        pending_reports.push_back(rep);
      end
      rearm();
    end
  endfunction

  function automatic void note_failure(string what);
    if (fail_count < 10) $display("ERROR %s", what);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sig_lo  = '0;
      sig_hi  = '0;
      care    = '1;
      len_reg = LEN_W'(1);
      rearm();
      pending_reports.delete();
      fail_count     = 0;
      found_checked  = 0;
      absent_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAT_LO: sig_lo  = cfg_data;
          CFG_PAT_HI: sig_hi  = cfg_data;
          CFG_CARE:   care    = cfg_data[SIG_BYTES-1:0];
          CFG_LEN:    len_reg = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_byte(in_data);
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("unexpected result found=%0b offset=%0d",
                                 out_data.found, out_data.match_offset));
        end else begin
          want = pending_reports.pop_front();
          if (want.found != out_data.found)
            note_failure($sformatf("found: expected %0b, got %0b (offset exp %0d got %0d)",
                                   want.found, out_data.found,
                                   want.match_offset, out_data.match_offset));
          else if (want.match_offset != out_data.match_offset)
            note_failure($sformatf("match_offset: expected %0d, got %0d",
                                   want.match_offset, out_data.match_offset));
          else if (want.found)
            found_checked++;
          else
            absent_checked++;
        end
      end
    end
    reports_waiting = pending_reports.size();
  end

endmodule

@@ tb/tb_masked_byte_signature_scan_unit.sv @@
// top of the signature scan testbench: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_masked_byte_signature_scan_unit;
  import mbss_pkg::*;

  localparam int RANDOM_BYTES = 950;
  localparam int PHASE_BYTES  = 90;

  // receiver back-pressure styles, picked anew at random while the test runs
  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_ALTERNATE,
    STALL_RUNS
  } stall_style_t;

  // how a random region is built around the signature
  typedef enum int unsigned {
    SHAPE_ONE_HIT,
    SHAPE_HIT_AT_END,
    SHAPE_TWO_HITS,
    SHAPE_NEAR_MISS,
    SHAPE_NOISE
  } region_shape_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int reports_waiting;
  int found_checked;
  int absent_checked;

  // signature as currently loaded, kept here only to plant hits in regions
  logic [7:0]           sig [SIG_BYTES];
  logic [SIG_BYTES-1:0] care;
  int unsigned          eff_len;

  int bytes_sent   = 0;
  int regions_sent = 0;
  int phases_run   = 0;
  int burst_left   = 0;
  bit gapless      = 1'b0;

  stall_style_t stall_style = STALL_NONE;
  int unsigned  cyc         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  masked_byte_signature_scan_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbss_match_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .reports_waiting (reports_waiting),
    .found_checked   (found_checked),
    .absent_checked  (absent_checked)
  );

  // result side stalls on its own pattern, independent of the sender;
  // the quiet style gives stretches with no back-pressure at all
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 128 == 0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:      out_stall <= 1'b0;
      STALL_COIN:      out_stall <= 1'($urandom_range(0, 1));
      STALL_ALTERNATE: out_stall <= (cyc % 2 == 1);
      default:         out_stall <= ((cyc / 8) % 3 == 0);
    endcase
  end

  // one register write; valid stays up across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all four registers; the words may carry junk above the used bits
  task automatic load_config(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [CFG_DATA_W-1:0] care_word,
                             input logic [CFG_DATA_W-1:0] len_word);
    logic [LEN_W-1:0] l;
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_CARE, care_word);
    write_reg(CFG_LEN, len_word);
    cfg_valid <= 1'b0;
    for (int j = 0; j < 8; j++) begin
      sig[j]     = lo[j*8 +: 8];
      sig[j + 8] = hi[j*8 +: 8];
    end
    care    = care_word[SIG_BYTES-1:0];
    l       = len_word[LEN_W-1:0];
    // zero length behaves as one, anything beyond the window as the full window
    eff_len = (l == 0) ? 1 : (l > SIG_BYTES) ? SIG_BYTES : l;
    phases_run++;
  endtask

  // one byte request, sent in bursts with random gaps unless the phase is gapless
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{data_byte: b, region_end: last};
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_region(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    regions_sent++;
  endtask

  // drop valid and wait until every outstanding result has been taken,
  // then let the clock run on, since a region can end with nothing to report
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes one instance of the signature at position at, wildcards random
  function automatic void plant(ref logic [7:0] bytes [$], input int at);
    for (int j = 0; j < eff_len; j++)
      bytes[at + j] = care[j] ? sig[j] : 8'($urandom);
  endfunction

  task automatic random_region();
    logic [7:0]    bytes [$];
    int            span;
    int            at;
    int            pick;
    region_shape_t shape;
    span  = $urandom_range(1, 2 * eff_len + 10);
    shape = region_shape_t'($urandom_range(0, 4));
    for (int i = 0; i < span; i++) bytes.push_back(8'($urandom));
    if (span >= eff_len) begin
      at = $urandom_range(0, span - eff_len);
      case (shape)
        SHAPE_ONE_HIT:    plant(bytes, at);
        // the match closes exactly on the region's final byte
        SHAPE_HIT_AT_END: plant(bytes, span - eff_len);
        SHAPE_TWO_HITS: begin
          plant(bytes, at);
          plant(bytes, $urandom_range(0, span - eff_len));
        end
        // one random byte of the planted copy spoiled if it is cared, so the region should come close but miss
        SHAPE_NEAR_MISS: begin
          plant(bytes, at);
          pick = $urandom_range(0, eff_len - 1);
          if (care[pick]) bytes[at + pick] = sig[pick] ^ 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
    end
    send_region(bytes);
  endtask

  // lengths cover the range ends and the out-of-range codes
  int unsigned len_plan [12] = '{1, 16, 0, 17, 31, 4, 9, 2, 16, 6, 13, 3};

  initial begin
    logic [7:0]            region [$];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] care_word;
    logic [CFG_DATA_W-1:0] len_word;
    int                    random_start;
    int                    phase_start;
    int                    p;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: four byte signature DE ?? FF 5A with byte 1 as wildcard
    load_config(64'h0000_0000_5AFF_00DE, 64'h0, 64'h0000_0000_0000_FFFD, 64'd4);
    // match from the first byte, closing on the final byte, wildcard differs
    region = '{8'hDE, 8'h77, 8'hFF, 8'h5A};
    send_region(region);
    // first match at offset 1, second one later must stay silent
    region = '{8'h00, 8'hDE, 8'h00, 8'hFF, 8'h5A, 8'hDE, 8'h11, 8'hFF, 8'h5A};
    send_region(region);
    // region shorter than the signature, then a one byte region
    region = '{8'hDE, 8'h00, 8'hFF};
    send_region(region);
    region = '{8'hFF};
    send_region(region);
    settle();

    // directed: every position wildcard, length code zero, junk in upper bits
    load_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFE0);
    region = '{8'hAB, 8'h00};
    send_region(region);
    region = '{8'hFF};
    send_region(region);
    settle();

    // random phases, each with a fresh signature, mask and length
    random_start = bytes_sent;
    p = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      lo        = (p % 6 == 3) ? '1 : {$urandom(), $urandom()};
      hi        = (p % 6 == 3) ? '0 : {$urandom(), $urandom()};
      care_word = {$urandom(), $urandom()};
      len_word  = {$urandom(), $urandom()};
      case (p % 4)
        0:       care_word[SIG_BYTES-1:0] = '1;
        1:       care_word[SIG_BYTES-1:0] = '0;
        default: ;
      endcase
      len_word[LEN_W-1:0] = LEN_W'(len_plan[p % 12]);
      load_config(lo, hi, care_word, len_word);
      gapless     = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES &&
             bytes_sent - random_start < RANDOM_BYTES)
        random_region();
      settle();
      p++;
    end

    $display("scanned %0d bytes in %0d regions across %0d signature settings",
             bytes_sent, regions_sent, phases_run);
    $display("compared %0d match reports and %0d no-match reports",
             found_checked, absent_checked);
    if (fail_count == 0 && reports_waiting == 0)
      $display("masked_byte_signature_scan_unit test passed");
    else
      $display("masked_byte_signature_scan_unit test failed");
    $finish;
  end

  // hard limit far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", reports_waiting);
    $display("masked_byte_signature_scan_unit test failed");
    $finish;
  end

endmodule

@@ masked_byte_signature_scan_unit.f @@
sv/mbss_pkg.sv
sv/mbss_cell.sv
sv/mbss_skid.sv
sv/masked_byte_signature_scan_unit.sv
sv/mbss_checker.sv
tb/mbss_match_checker.sv
tb/tb_masked_byte_signature_scan_unit.sv
